/* rtl/tof_dspacing_converter_macros.svh */
// ----------------------------------------------------------------------------
// TOF / d-spacing converter assertion macros
// Shared property wrappers used by the converter RTL.
// ----------------------------------------------------------------------------
`ifndef TOF_DSPACING_CONVERTER_MACROS_SVH
`define TOF_DSPACING_CONVERTER_MACROS_SVH

// same-cycle implication
`define TDC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tdc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdc_pkg
// Shared types, constants and arithmetic helpers of the TOF / d-spacing
// converter.
// ----------------------------------------------------------------------------
package tdc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int VAL_W     = 40;
  localparam int FAC_W     = 64;
  localparam int PROD_W    = FAC_W + VAL_W;       // signed 64 x signed 40
  localparam int WIDE_W    = PROD_W + 2;          // headroom for sums
  localparam int DIV_W     = VAL_W + 2 * FRAC_BITS; // divider numerator width
  localparam int SQRT_STEPS = FAC_W / 2;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINEAR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUAD      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TZERO     = 2'd3;

  localparam logic signed [VAL_W-1:0] LINEAR_RESET = VAL_W'(64'sd1 <<< FRAC_BITS);

  localparam logic signed [WIDE_W-1:0] S64_MAX = {{(WIDE_W-63){1'b0}}, {63{1'b1}}};
  localparam logic signed [WIDE_W-1:0] S64_MIN = -S64_MAX - WIDE_W'(1);
  localparam logic signed [WIDE_W-1:0] V_MAX = {{(WIDE_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] V_MIN = -V_MAX - WIDE_W'(1);

  // multiplier operands as magnitudes plus product sign
  typedef struct packed {
    logic [FAC_W-1:0] a;
    logic [VAL_W-1:0] b;
    logic             neg;
  } mul_a_t;

  // four 32x20 partial products
  typedef struct packed {
    logic [3:0][51:0] p;
    logic             neg;
  } mul_p_t;

  // derived factors from the calibration unit
  typedef struct packed {
    logic signed [VAL_W-1:0] rc;
    logic signed [FAC_W-1:0] sf;
    logic signed [FAC_W-1:0] ot;
    logic                    busy;
  } tdc_fac_t;

  // everything the datapath needs from configuration
  typedef struct packed {
    logic                    dir;
    logic                    quad;
    logic                    lin;
    logic signed [VAL_W-1:0] lc;
    logic signed [VAL_W-1:0] qc;
    logic signed [VAL_W-1:0] tz;
    logic signed [VAL_W-1:0] rc;
    logic signed [FAC_W-1:0] sf;
    logic signed [FAC_W-1:0] ot;
    logic                    busy;
  } tdc_coef_t;

  function automatic mul_a_t mul_a(logic signed [FAC_W-1:0] a, logic signed [VAL_W-1:0] b);
    mul_a_t m;
    m.a   = a[FAC_W-1] ? FAC_W'(-a) : FAC_W'(a);
    m.b   = b[VAL_W-1] ? VAL_W'(-b) : VAL_W'(b);
    m.neg = a[FAC_W-1] ^ b[VAL_W-1];
    return m;
  endfunction

  function automatic mul_p_t mul_pp(mul_a_t m);
    mul_p_t r;
    r.p[0] = 52'(m.a[31:0])  * 52'(m.b[19:0]);
    r.p[1] = 52'(m.a[31:0])  * 52'(m.b[39:20]);
    r.p[2] = 52'(m.a[63:32]) * 52'(m.b[19:0]);
    r.p[3] = 52'(m.a[63:32]) * 52'(m.b[39:20]);
    r.neg  = m.neg;
    return r;
  endfunction

  function automatic logic signed [PROD_W-1:0] mul_sum(mul_p_t m);
    logic [PROD_W-1:0] mg;
    mg = PROD_W'(m.p[0]) + (PROD_W'(m.p[1]) << 20) + (PROD_W'(m.p[2]) << 32)
       + (PROD_W'(m.p[3]) << 52);
    return m.neg ? -$signed(mg) : $signed(mg);
  endfunction

  function automatic logic signed [FAC_W-1:0] sat64(logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] c;
    c = (v > S64_MAX) ? S64_MAX : ((v < S64_MIN) ? S64_MIN : v);
    return c[FAC_W-1:0];
  endfunction

  function automatic logic signed [VAL_W-1:0] clamp40(logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] c;
    c = (v > V_MAX) ? V_MAX : ((v < V_MIN) ? V_MIN : v);
    return c[VAL_W-1:0];
  endfunction

endpackage

/* rtl/tof_dspacing_converter.sv */
`timescale 1ns / 1ps
// One item per cycle sustained while the result side accepts and no factor recompute runs.
// Depth: 32-stage integer square root, five multiply/saturate stages, the output register.
// Any output stall freezes the whole pipeline; in_tready is low then and during a recompute.
// Reset (rst_n, synchronous) restores registers and recomputes factors with in_tready low;
// every config write repeats the recompute, which is shortest for a zero calibration.
// ----------------------------------------------------------------------------
// tof_dspacing_converter
// Streaming converter between time of flight and d-spacing with a quadratic
// calibration held in configuration registers.
// ----------------------------------------------------------------------------
module tof_dspacing_converter (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tdc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tdc_pkg::VAL_W-1:0]        cfg_data,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [tdc_pkg::VAL_W-1:0]        in_tdata,   // [39:0] sample_value
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [tdc_pkg::VAL_W-1:0]        out_tdata,  // [39:0] converted_value
  output logic [0:0]                       out_tuser   // [0] invalid
);
  import tdc_pkg::*;

  logic                    dir_r;
  logic signed [VAL_W-1:0] lc_r;
  logic signed [VAL_W-1:0] qc_r;
  logic signed [VAL_W-1:0] tz_r;
  logic                    cfg_wr;
  tdc_fac_t                fac;
  tdc_coef_t               coef;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= 1'b0;
      lc_r  <= LINEAR_RESET;
      qc_r  <= '0;
      tz_r  <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_DIRECTION: dir_r <= cfg_data[0];
        CFG_LINEAR:    lc_r  <= cfg_data;
        CFG_QUAD:      qc_r  <= cfg_data;
        CFG_TZERO:     tz_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  tdc_derive u_derive (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cfg_wr),
    .lc    (lc_r),
    .qc    (qc_r),
    .tz    (tz_r),
    .fac   (fac)
  );

  always_comb begin
    coef.dir  = dir_r;
    coef.quad = (qc_r != '0);
    coef.lin  = (lc_r != '0);
    coef.lc   = lc_r;
    coef.qc   = qc_r;
    coef.tz   = tz_r;
    coef.rc   = fac.rc;
    coef.sf   = fac.sf;
    coef.ot   = fac.ot;
    coef.busy = fac.busy;
  end

  tdc_pipe u_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .coef       (coef),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

/* rtl/tdc_derive.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdc_derive
// Computes root center, scale and offset factors from the calibration
// registers with a bit-serial divider and a shared partial-product multiplier.
// ----------------------------------------------------------------------------
module tdc_derive (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic signed [tdc_pkg::VAL_W-1:0] lc,
  input  logic signed [tdc_pkg::VAL_W-1:0] qc,
  input  logic signed [tdc_pkg::VAL_W-1:0] tz,
  output tdc_pkg::tdc_fac_t               fac
);
  import tdc_pkg::*;
`include "tof_dspacing_converter_macros.svh"

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_START = 4'd1;
  localparam logic [3:0] ST_DIV_A = 4'd2;
  localparam logic [3:0] ST_END_A = 4'd3;
  localparam logic [3:0] ST_DIV_B = 4'd4;
  localparam logic [3:0] ST_END_B = 4'd5;
  localparam logic [3:0] ST_MUL_A1 = 4'd6;
  localparam logic [3:0] ST_MUL_A2 = 4'd7;
  localparam logic [3:0] ST_MUL_B1 = 4'd8;
  localparam logic [3:0] ST_MUL_B2 = 4'd9;
  localparam logic [3:0] ST_FIN   = 4'd10;

  localparam int CNT_W = $clog2(DIV_W);

  logic [3:0]                state_r, state_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [DIV_W-1:0]          num_r, num_nxt;
  logic [VAL_W-1:0]          rem_r, rem_nxt;
  logic [VAL_W-1:0]          den_r, den_nxt;
  logic                      qneg_r, qneg_nxt;
  logic                      quad_r, quad_nxt;
  logic signed [VAL_W-1:0]   rc_r, rc_nxt;
  logic signed [FAC_W-1:0]   sf_r, sf_nxt;
  logic signed [FAC_W-1:0]   ot_r, ot_nxt;
  mul_a_t                    mop_r, mop_nxt;
  mul_p_t                    mpp_r, mpp_nxt;
  logic signed [PROD_W-1:0]  p1_r, p1_nxt;
  logic signed [PROD_W-1:0]  p2_r, p2_nxt;

  logic                      sel_quad;
  logic                      sel_b;
  logic                      load;
  logic signed [WIDE_W-1:0]  dnum;
  logic signed [VAL_W-1:0]   dden;
  logic [WIDE_W-1:0]         dnum_mag;
  logic [VAL_W:0]            rem_sh;
  logic                      ge;
  logic signed [WIDE_W-1:0]  qs;

  always_comb begin
    sel_quad = (state_r == ST_START) ? (qc != '0) : quad_r;
    sel_b    = (state_r == ST_END_A);
    if (sel_quad) begin
      dnum = sel_b ? (WIDE_W'(1) <<< (3 * FRAC_BITS))
                   : (-(WIDE_W'(lc)) <<< (2 * FRAC_BITS - 1));
      dden = qc;
    end else begin
      dnum = sel_b ? (-(WIDE_W'(tz)) <<< FRAC_BITS)
                   : (WIDE_W'(1) <<< (3 * FRAC_BITS));
      dden = lc;
    end
    dnum_mag = dnum[WIDE_W-1] ? WIDE_W'(-dnum) : WIDE_W'(dnum);
    load = ((state_r == ST_START) && ((qc != '0) || (lc != '0))) || (state_r == ST_END_A);

    rem_sh = {rem_r, num_r[DIV_W-1]};
    ge     = rem_sh >= {1'b0, den_r};
    qs     = qneg_r ? -$signed(WIDE_W'(num_r)) : $signed(WIDE_W'(num_r));
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    num_nxt   = num_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    qneg_nxt  = qneg_r;
    quad_nxt  = quad_r;
    rc_nxt    = rc_r;
    sf_nxt    = sf_r;
    ot_nxt    = ot_r;
    mop_nxt   = mop_r;
    mpp_nxt   = mpp_r;
    p1_nxt    = p1_r;
    p2_nxt    = p2_r;

    if (load) begin
      num_nxt  = dnum_mag[DIV_W-1:0];
      den_nxt  = dden[VAL_W-1] ? VAL_W'(-dden) : VAL_W'(dden);
      qneg_nxt = dnum[WIDE_W-1] ^ dden[VAL_W-1];
      rem_nxt  = '0;
      cnt_nxt  = '0;
    end

    case (state_r)
      ST_IDLE: begin
      end
      ST_START: begin
        quad_nxt = (qc != '0);
        if ((qc != '0) || (lc != '0)) begin
          state_nxt = ST_DIV_A;
        end else begin
          rc_nxt    = '0;
          sf_nxt    = '0;
          ot_nxt    = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV_A, ST_DIV_B: begin
        rem_nxt = ge ? VAL_W'(rem_sh - {1'b0, den_r}) : rem_sh[VAL_W-1:0];
        num_nxt = {num_r[DIV_W-2:0], ge};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_W - 1)) begin
          state_nxt = (state_r == ST_DIV_A) ? ST_END_A : ST_END_B;
        end
      end
      ST_END_A: begin
        if (quad_r) begin
          rc_nxt = clamp40(qs);
        end else begin
          rc_nxt = '0;
          sf_nxt = sat64(qs);
        end
        state_nxt = ST_DIV_B;
      end
      ST_END_B: begin
        if (quad_r) begin
          sf_nxt    = sat64(qs);
          mop_nxt   = mul_a(FAC_W'(rc_r), rc_r);
          state_nxt = ST_MUL_A1;
        end else begin
          ot_nxt    = sat64(qs);
          state_nxt = ST_IDLE;
        end
      end
      ST_MUL_A1: begin
        mpp_nxt   = mul_pp(mop_r);
        state_nxt = ST_MUL_A2;
      end
      ST_MUL_A2: begin
        p1_nxt    = mul_sum(mpp_r);
        mop_nxt   = mul_a(sf_r, tz);
        state_nxt = ST_MUL_B1;
      end
      ST_MUL_B1: begin
        mpp_nxt   = mul_pp(mop_r);
        state_nxt = ST_MUL_B2;
      end
      ST_MUL_B2: begin
        p2_nxt    = mul_sum(mpp_r);
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        ot_nxt    = sat64(WIDE_W'(p1_r) - WIDE_W'(p2_r));
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (start) begin
      state_nxt = ST_START;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_START;
      cnt_r   <= '0;
      quad_r  <= 1'b0;
      rc_r    <= '0;
      sf_r    <= '0;
      ot_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      quad_r  <= quad_nxt;
      rc_r    <= rc_nxt;
      sf_r    <= sf_nxt;
      ot_r    <= ot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    qneg_r <= qneg_nxt;
    mop_r  <= mop_nxt;
    mpp_r  <= mpp_nxt;
    p1_r   <= p1_nxt;
    p2_r   <= p2_nxt;
  end

  assign fac.rc   = rc_r;
  assign fac.sf   = sf_r;
  assign fac.ot   = ot_r;
  assign fac.busy = (state_r != ST_IDLE);

  `TDC_ASSERT_NEXT(a_start_busy, clk, rst_n, start, fac.busy, "derive not busy after start")
  `TDC_ASSERT_NOW(a_div_cnt, clk, rst_n, (state_r == ST_DIV_A) || (state_r == ST_DIV_B), cnt_r < CNT_W'(DIV_W), "divider step count overrun")
  `TDC_ASSERT_NOW(a_zero_cal, clk, rst_n, (state_r == ST_IDLE) && (qc == '0) && (lc == '0), (sf_r == '0) && (ot_r == '0) && (rc_r == '0), "factors not cleared for zero calibration")

endmodule

/* rtl/tdc_pipe.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdc_pipe
// Per-item conversion pipeline: split multipliers, saturation, 32-stage
// integer square root and root selection, with a stall-all output stage.
// ----------------------------------------------------------------------------
module tdc_pipe (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tdc_pkg::tdc_coef_t          coef,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [tdc_pkg::VAL_W-1:0]   in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [tdc_pkg::VAL_W-1:0]   out_tdata,
  output logic [0:0]                  out_tuser
);
  import tdc_pkg::*;
`include "tof_dspacing_converter_macros.svh"

  localparam int SQ0   = 5;                 // first square-root stage
  localparam int NSTG  = SQ0 + SQRT_STEPS + 1;
  localparam int LAST  = NSTG - 1;

  logic [NSTG-1:0] vld_r;
  logic            adv;
  logic            take;

  logic signed [VAL_W-1:0]  x0_r, x1_r, x2_r, x3_r;
  mul_a_t                   ma1_r, ma2_r, ma3_r;
  mul_p_t                   mp1_r, mp2_r, mp3_r;
  logic signed [PROD_W-1:0] m1_r, m2_r, m3_r;
  logic signed [PROD_W-1:0] m2c4_r, m2c5_r, m2c6_r;
  logic [FAC_W-1:0]         rad4_r;
  logic signed [VAL_W-1:0]  res4_r;
  logic                     bad4_r;

  logic [FAC_W-1:0]         sq_v_r [SQRT_STEPS];
  logic [FAC_W-1:0]         sq_r_r [SQRT_STEPS];
  logic signed [VAL_W-1:0]  car_res_r [SQRT_STEPS];
  logic                     car_bad_r [SQRT_STEPS];

  logic signed [VAL_W-1:0]  out_val_r;
  logic                     out_bad_r;

  logic signed [FAC_W-1:0]  q4;
  logic signed [WIDE_W-1:0] rad4;
  logic signed [WIDE_W-1:0] lin4;
  logic signed [WIDE_W-1:0] acc6;
  logic signed [VAL_W-1:0]  tof6;
  logic signed [WIDE_W-1:0] sw;
  logic signed [WIDE_W-1:0] rcw;
  logic signed [VAL_W-1:0]  qres;

  assign adv       = !vld_r[LAST] || out_tready;
  assign in_tready = adv && !coef.busy;
  assign take      = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], take};
    end
  end

  // front end: two multiplies in parallel, three stages each
  always_ff @(posedge clk) begin
    if (adv) begin
      x0_r  <= in_tdata;
      ma1_r <= mul_a(coef.dir ? FAC_W'(coef.qc) : coef.sf, x0_r);
      ma2_r <= mul_a(FAC_W'(coef.lc), x0_r);
      x1_r  <= x0_r;
      mp1_r <= mul_pp(ma1_r);
      mp2_r <= mul_pp(ma2_r);
      x2_r  <= x1_r;
      m1_r  <= mul_sum(mp1_r);
      m2_r  <= mul_sum(mp2_r);
      x3_r  <= x2_r;
    end
  end

  always_comb begin
    q4   = sat64(WIDE_W'(m1_r) >>> FRAC_BITS);
    rad4 = WIDE_W'(m1_r) + WIDE_W'(coef.ot);
    lin4 = (WIDE_W'(m1_r) >>> (2 * FRAC_BITS)) + WIDE_W'(coef.ot);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ma3_r  <= mul_a(q4, x3_r);
      m2c4_r <= m2_r;
      rad4_r <= rad4[WIDE_W-1] ? '0 : FAC_W'(sat64(rad4));
      if (coef.dir || coef.quad) begin
        res4_r <= '0;
        bad4_r <= !coef.dir && rad4[WIDE_W-1];
      end else if (coef.lin) begin
        res4_r <= clamp40(lin4);
        bad4_r <= 1'b0;
      end else begin
        res4_r <= '0;
        bad4_r <= 1'b1;
      end
    end
  end

  // d to TOF tail runs beside the first three root stages
  always_comb begin
    acc6 = (WIDE_W'(m2c6_r) <<< FRAC_BITS) + WIDE_W'(m3_r)
         + (WIDE_W'(coef.tz) <<< (2 * FRAC_BITS));
    tof6 = clamp40(acc6 >>> (2 * FRAC_BITS));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mp3_r  <= mul_pp(ma3_r);
      m2c5_r <= m2c4_r;
      m3_r   <= mul_sum(mp3_r);
      m2c6_r <= m2c5_r;
    end
  end

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    localparam logic [FAC_W-1:0] BIT = FAC_W'(1) << (FAC_W - 2 - 2 * g);
    logic [FAC_W-1:0] v_in;
    logic [FAC_W-1:0] r_in;
    logic [FAC_W-1:0] trial;
    logic             fits;

    if (g == 0) begin : g_first
      assign v_in = rad4_r;
      assign r_in = '0;
    end else begin : g_rest
      assign v_in = sq_v_r[g-1];
      assign r_in = sq_r_r[g-1];
    end

    assign trial = r_in + BIT;
    assign fits  = v_in >= trial;

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_v_r[g] <= fits ? v_in - trial : v_in;
        sq_r_r[g] <= fits ? (r_in >> 1) + BIT : (r_in >> 1);
      end
    end

    if (g == 0) begin : g_car0
      always_ff @(posedge clk) begin
        if (adv) begin
          car_res_r[g] <= res4_r;
          car_bad_r[g] <= bad4_r;
        end
      end
    end else if (g == 2) begin : g_car2
      always_ff @(posedge clk) begin
        if (adv) begin
          car_res_r[g] <= coef.dir ? tof6 : car_res_r[g-1];
          car_bad_r[g] <= coef.dir ? 1'b0 : car_bad_r[g-1];
        end
      end
    end else begin : g_carn
      always_ff @(posedge clk) begin
        if (adv) begin
          car_res_r[g] <= car_res_r[g-1];
          car_bad_r[g] <= car_bad_r[g-1];
        end
      end
    end
  end

  // pick the root on the side of the center that the stream expects
  always_comb begin
    sw   = $signed(WIDE_W'(sq_r_r[SQRT_STEPS-1]));
    rcw  = WIDE_W'(coef.rc);
    qres = clamp40((sw < rcw) ? rcw - sw : rcw + sw);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_bad_r <= car_bad_r[SQRT_STEPS-1];
      if (!coef.dir && coef.quad && !car_bad_r[SQRT_STEPS-1]) begin
        out_val_r <= qres;
      end else begin
        out_val_r <= car_res_r[SQRT_STEPS-1];
      end
    end
  end

  assign out_tvalid = vld_r[LAST];
  assign out_tdata  = out_val_r;
  assign out_tuser  = out_bad_r;

  `TDC_ASSERT_NOW(a_no_take_busy, clk, rst_n, in_tready, !coef.busy, "input taken while factors recompute")
  `TDC_ASSERT_NOW(a_bad_zero, clk, rst_n, out_tvalid && out_tuser[0], out_tdata == '0, "invalid result with nonzero value")
  `TDC_ASSERT_NOW(a_fwd_valid, clk, rst_n, out_tvalid && coef.dir, !out_tuser[0], "d to TOF flagged invalid")

endmodule

/* tb/tdc_scoreboard.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdc_scoreboard
// Watches the configuration, input and result channels of the converter,
// keeps its own copy of the calibration and derived factors, predicts each
// conversion and compares the results in order.
// ----------------------------------------------------------------------------
module tdc_scoreboard (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [tdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tdc_pkg::VAL_W-1:0]  cfg_data,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [tdc_pkg::VAL_W-1:0]  in_tdata,
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [tdc_pkg::VAL_W-1:0]  out_tdata,
  input  logic [0:0]                 out_tuser,
  output int                         err_count,
  output int                         pending
);
  import tdc_pkg::*;

  typedef logic signed [127:0] wide_t;
  typedef struct {
    logic [VAL_W-1:0] value;
    logic             bad;
  } conv_t;

  localparam wide_t W64_MAX = 128'sh7fff_ffff_ffff_ffff;
  localparam wide_t W64_MIN = -W64_MAX - 128'sd1;
  localparam wide_t W40_MAX = 128'sh7f_ffff_ffff;
  localparam wide_t W40_MIN = -W40_MAX - 128'sd1;

  logic                    to_tof;
  logic signed [VAL_W-1:0] difc, difa, tzero;
  logic signed [63:0]      center, scale, offset;
  conv_t                   conv_q[$];

  function automatic logic signed [63:0] sat_s64(wide_t v);
    if (v > W64_MAX) return W64_MAX[63:0];
    if (v < W64_MIN) return W64_MIN[63:0];
    return v[63:0];
  endfunction

  function automatic logic signed [63:0] clamp_val(wide_t v);
    if (v > W40_MAX) return W40_MAX[63:0];
    if (v < W40_MIN) return W40_MIN[63:0];
    return v[63:0];
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // factors are recomputed on reset and after every register write
  task automatic update_factors();
    wide_t c, a, t, rc, sf;
    c = difc;
    a = difa;
    t = tzero;
    if (difa != 0) begin
      center = clamp_val(sat_s64(((-c) <<< 31) / a));
      scale  = sat_s64((128'sd1 <<< 48) / a);
      rc     = center;
      sf     = scale;
      offset = sat_s64(rc * rc - t * sf);
    end else if (difc != 0) begin
      center = 0;
      scale  = sat_s64((128'sd1 <<< 48) / c);
      offset = sat_s64(((-t) <<< 16) / c);
    end else begin
      center = 0;
      scale  = 0;
      offset = 0;
    end
  endtask

  function automatic conv_t convert(logic signed [VAL_W-1:0] sample);
    conv_t r;
    wide_t x, q, acc, rad, s;
    logic signed [63:0] q64, res;
    x   = sample;
    res = 0;
    r.bad = 1'b0;
    if (to_tof) begin
      q64 = sat_s64((wide_t'(difa) * x) >>> 16);
      q   = q64;
      acc = ((wide_t'(difc) * x) <<< 16) + q * x + (wide_t'(tzero) <<< 32);
      res = clamp_val(sat_s64(acc >>> 32));
    end else if (difa != 0) begin
      rad = x * wide_t'(scale) + wide_t'(offset);
      if (rad < 0) begin
        r.bad = 1'b1;
      end else begin
        s = $signed({64'd0, int_sqrt(sat_s64(rad))});
        res = clamp_val((s < wide_t'(center)) ? wide_t'(center) - s : wide_t'(center) + s);
      end
    end else if (difc != 0) begin
      res = clamp_val(sat_s64(((x * wide_t'(scale)) >>> 32) + wide_t'(offset)));
    end else begin
      r.bad = 1'b1;
    end
    r.value = res[VAL_W-1:0];
    return r;
  endfunction

  assign pending = conv_q.size();

  always @(posedge clk) begin
    conv_t exp_c;
    if (!rst_n) begin
      to_tof = 1'b0;
      difc   = LINEAR_RESET;
      difa   = 0;
      tzero  = 0;
      update_factors();
      conv_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DIRECTION: to_tof = cfg_data[0];
          CFG_LINEAR:    difc   = cfg_data;
          CFG_QUAD:      difa   = cfg_data;
          CFG_TZERO:     tzero  = cfg_data;
          default: ;
        endcase
        update_factors();
      end
      if (in_tvalid && in_tready) conv_q.push_back(convert(in_tdata));
      if (out_tvalid && out_tready) begin
        if (conv_q.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected result: value=%h invalid=%b", out_tdata, out_tuser[0]);
        end else begin
          exp_c = conv_q.pop_front();
          if (exp_c.value !== out_tdata || exp_c.bad !== out_tuser[0]) begin
            err_count++;
            if (err_count <= 10)
              $display("mismatch: expected value=%h invalid=%b, got value=%h invalid=%b",
                       exp_c.value, exp_c.bad, out_tdata, out_tuser[0]);
          end
        end
      end
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the converter through a sequence of calibrations and directions
// with directed and random samples, bursty input and a stalling result side.
// ----------------------------------------------------------------------------
module tb_top;
  import tdc_pkg::*;

  localparam int DRAIN_CYCLES = 60;
  localparam int WDOG_LIMIT   = 4000;
  localparam int PHASES       = 12;
  localparam int RAND_PER_PHASE = 145;

  logic                 clk, rst_n;
  logic                 cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [VAL_W-1:0]     cfg_data;
  logic                 in_tvalid, in_tready;
  logic [VAL_W-1:0]     in_tdata;
  logic                 out_tvalid, out_tready;
  logic [VAL_W-1:0]     out_tdata;
  logic [0:0]           out_tuser;
  int                   err_count, pending;
  int                   burst_left;
  logic                 long_hold;
  int                   idle_cycles;

  tof_dspacing_converter dut (.*);

  tdc_scoreboard u_scoreboard (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 40'h7f_ffff_ffff;
      1:       return 40'h80_0000_0000;
      2:       return 40'(signed'(20'($urandom)));
      3:       return 40'($urandom_range(0, 3)) - 40'd1;
      4, 5:    return 40'(32'($urandom_range(0, 32'h00ff_ffff)));
      default: return {8'($urandom), 32'($urandom)};
    endcase
  endfunction

  task automatic send(input logic [VAL_W-1:0] x);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= x;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    burst_left--;
  endtask

  // waits for the pipeline to empty before a register write
  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_cal(input logic dir, input logic [VAL_W-1:0] lc,
                           input logic [VAL_W-1:0] qc, input logic [VAL_W-1:0] tz);
    logic [VAL_W-1:0] vals[4];
    logic [CFG_IDX_W-1:0] idx[4];
    vals = '{40'(dir), lc, qc, tz};
    idx  = '{CFG_DIRECTION, CFG_LINEAR, CFG_QUAD, CFG_TZERO};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [VAL_W-1:0] pick_coef();
    case ($urandom_range(0, 5))
      0:       return 40'h7f_ffff_ffff;
      1:       return 40'h80_0000_0000;
      2:       return 40'(signed'(24'($urandom)));
      3:       return 40'(signed'(33'({$urandom, 1'b0})));
      default: return {8'($urandom), 32'($urandom)};
    endcase
  endfunction

  // result side: random stall patterns drawn in turn, one long hold on request
  initial begin
    int mode;
    bit held;
    out_tready = 1'b1;
    held = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      for (int i = 0; i < 64; i++) begin
        @(negedge clk);
        if (long_hold && !held) begin
          held = 1'b1;
          out_tready <= 1'b0;
          repeat (400) @(negedge clk);
        end
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= $urandom_range(0, 1);
          2:       out_tready <= ($urandom_range(0, 7) != 0);
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)
        || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    @(posedge clk);
    while (idle_cycles < WDOG_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [VAL_W-1:0] edge_vals[6];
    edge_vals = '{40'h0, 40'h1, 40'hff_ffff_ffff, 40'h7f_ffff_ffff, 40'h80_0000_0000,
                  40'h0_0001_0000};
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_DIRECTION;
    cfg_data  = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    long_hold = 1'b0;
    burst_left = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain();
        case (p)
          1: write_cal(1'b0, 40'sd5000 <<< 16, 40'h0, 40'sd10 <<< 16);
          2: write_cal(1'b0, 40'sd5000 <<< 16, -(40'sd1 <<< 32), 40'sd3 <<< 16);
          3: write_cal(1'b1, 40'sd5000 <<< 16, -(40'sd1 <<< 32), 40'sd3 <<< 16);
          4: write_cal(1'b0, 40'h0, 40'h0, pick_coef());
          5: write_cal(1'b0, 40'h7f_ffff_ffff, 40'h7f_ffff_ffff, 40'h80_0000_0000);
          6: write_cal(1'b1, 40'h80_0000_0000, 40'h80_0000_0000, 40'h7f_ffff_ffff);
          7: write_cal(1'b0, 40'h0, 40'h1, pick_coef());
          8: write_cal(1'b0, 40'sd2000 <<< 16, 40'sd3 <<< 28, -(40'sd5 <<< 16));
          default: write_cal(1'($urandom), pick_coef(), pick_coef(), pick_coef());
        endcase
      end
      if (p == 0 || p == 2 || p == 3 || p == 5)
        foreach (edge_vals[i]) send(edge_vals[i]);
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        if (p == 3 && i == 20) long_hold = 1'b1;
        send(pick_value());
      end
    end

    drain();
    if (err_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/tdc_pkg.sv
rtl/tdc_derive.sv
rtl/tdc_pipe.sv
rtl/tof_dspacing_converter.sv
tb/tdc_scoreboard.sv
tb/tb_top.sv
